// ===== hdl/hcsd_pkg.sv =====
// hcsd_pkg: types, constants and round functions of the hchacha20 subkey derivation
// used by hchacha20_subkey_derive; no dependencies
package hcsd_pkg;

   localparam int ROUND_COUNT = 20;
   localparam int PAIR_COUNT  = (ROUND_COUNT + 1) / 2;
   // one stage per half round, two halves per round, two rounds per pair
   localparam int STAGE_COUNT = PAIR_COUNT * 4;

   localparam int WORD_WIDTH      = 32;
   localparam int WORD_COUNT      = 16;
   localparam int FIELD_WIDTH     = 64;
   localparam int KEY_REG_COUNT   = 4;
   localparam int CSR_INDEX_WIDTH = $clog2(KEY_REG_COUNT);

   typedef logic [WORD_WIDTH-1:0]                  word_type;
   typedef logic [WORD_COUNT-1:0][WORD_WIDTH-1:0]  state_type;
   typedef logic [FIELD_WIDTH-1:0]                 field_type;

   // "expand 32-byte k"
   localparam word_type SIGMA_0 = 32'h6170_7865;
   localparam word_type SIGMA_1 = 32'h3320_646e;
   localparam word_type SIGMA_2 = 32'h7962_2d32;
   localparam word_type SIGMA_3 = 32'h6b20_6574;

   localparam int ROT_A = 16;
   localparam int ROT_B = 12;
   localparam int ROT_C = 8;
   localparam int ROT_D = 7;

   function automatic word_type rotl(word_type v, int n);
      return (v << n) | (v >> (WORD_WIDTH - n));
   endfunction

   // half of a column or diagonal round: two add/xor/rotate steps on all four quarters
   function automatic state_type round_half(state_type s, logic diag, logic second);
      state_type r;
      logic [1:0] qi;
      logic [3:0] ia;
      logic [3:0] ib;
      logic [3:0] ic;
      logic [3:0] id;
      word_type wa;
      word_type wb;
      word_type wc;
      word_type wd;
      r = s;
      for (int q = 0; q < 4; q++) begin
         qi = 2'(q);
         ia = {2'b00, qi};
         ib = {2'b01, qi + (diag ? 2'd1 : 2'd0)};
         ic = {2'b10, qi + (diag ? 2'd2 : 2'd0)};
         id = {2'b11, qi + (diag ? 2'd3 : 2'd0)};
         wa = s[ia] + s[ib];
         wd = rotl(s[id] ^ wa, second ? ROT_C : ROT_A);
         wc = s[ic] + wd;
         wb = rotl(s[ib] ^ wc, second ? ROT_D : ROT_B);
         r[ia] = wa;
         r[ib] = wb;
         r[ic] = wc;
         r[id] = wd;
      end
      return r;
   endfunction

endpackage

// ===== hdl/hchacha20_subkey_derive.sv =====
// hchacha20_subkey_derive: fully pipelined hchacha20 subkey derivation
// depends on hcsd_pkg
//
// channel   direction  ports                                   transfer
// req       in         req_valid/req_ready, 2 x 64-bit nonce   valid & ready
// rsp       out        rsp_valid/rsp_ready, 4 x 64-bit subkey  valid & ready
// csr       in         csr_write, csr_index, csr_write_data    csr_write
//
// STAGE_COUNT pipeline stages, one stage per half round
// a new nonce is taken every cycle while the result side keeps up
// a stalled result holds its stage; bubbles ahead of it are still filled
// synchronous active-high reset clears all valid bits and the key registers
module hchacha20_subkey_derive
   import hcsd_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,

   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [63:0]                req_nonce_bytes_0_7,
   input  logic [63:0]                req_nonce_bytes_8_15,

   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [63:0]                rsp_subkey_bytes_0_7,
   output logic [63:0]                rsp_subkey_bytes_8_15,
   output logic [63:0]                rsp_subkey_bytes_16_23,
   output logic [63:0]                rsp_subkey_bytes_24_31,

   input  logic                       csr_write,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [63:0]                csr_write_data
);

   field_type                key_ff [KEY_REG_COUNT];
   state_type                init_state;
   logic [STAGE_COUNT-1:0]   stage_valid_ff;
   logic [STAGE_COUNT-1:0]   stage_ready;
   state_type                stage_data_ff [STAGE_COUNT];
   state_type                stage_data_in [STAGE_COUNT];
   logic [STAGE_COUNT-1:0]   stage_valid_in;

   // key registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < KEY_REG_COUNT; i++) begin
            key_ff[i] <= '0;
         end
      end else if (csr_write) begin
         key_ff[csr_index] <= csr_write_data;
      end
   end

   always_comb begin
      init_state[0]  = SIGMA_0;
      init_state[1]  = SIGMA_1;
      init_state[2]  = SIGMA_2;
      init_state[3]  = SIGMA_3;
      for (int i = 0; i < KEY_REG_COUNT; i++) begin
         init_state[4 + 2*i]     = key_ff[i][31:0];
         init_state[4 + 2*i + 1] = key_ff[i][63:32];
      end
      init_state[12] = req_nonce_bytes_0_7[31:0];
      init_state[13] = req_nonce_bytes_0_7[63:32];
      init_state[14] = req_nonce_bytes_8_15[31:0];
      init_state[15] = req_nonce_bytes_8_15[63:32];
   end

   assign stage_ready[STAGE_COUNT-1] = !stage_valid_ff[STAGE_COUNT-1] || rsp_ready;

   for (genvar g = 0; g < STAGE_COUNT; g++) begin : g_stage
      localparam logic DIAG   = 1'((g / 2) % 2);
      localparam logic SECOND = 1'(g % 2);

      if (g < STAGE_COUNT - 1) begin : g_ready
         assign stage_ready[g] = !stage_valid_ff[g] || stage_ready[g+1];
      end

      if (g == 0) begin : g_first
         assign stage_valid_in[g] = req_valid;
         assign stage_data_in[g]  = round_half(init_state, DIAG, SECOND);
      end else begin : g_next
         assign stage_valid_in[g] = stage_valid_ff[g-1];
         assign stage_data_in[g]  = round_half(stage_data_ff[g-1], DIAG, SECOND);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            stage_valid_ff[g] <= 1'b0;
         end else if (stage_ready[g]) begin
            stage_valid_ff[g] <= stage_valid_in[g];
         end
      end

      always_ff @(posedge clock) begin
         if (stage_ready[g] && stage_valid_in[g]) begin
            stage_data_ff[g] <= stage_data_in[g];
         end
      end
   end

   assign req_ready = stage_ready[0];
   assign rsp_valid = stage_valid_ff[STAGE_COUNT-1];

   assign rsp_subkey_bytes_0_7   = {stage_data_ff[STAGE_COUNT-1][1],
                                    stage_data_ff[STAGE_COUNT-1][0]};
   assign rsp_subkey_bytes_8_15  = {stage_data_ff[STAGE_COUNT-1][3],
                                    stage_data_ff[STAGE_COUNT-1][2]};
   assign rsp_subkey_bytes_16_23 = {stage_data_ff[STAGE_COUNT-1][13],
                                    stage_data_ff[STAGE_COUNT-1][12]};
   assign rsp_subkey_bytes_24_31 = {stage_data_ff[STAGE_COUNT-1][15],
                                    stage_data_ff[STAGE_COUNT-1][14]};

endmodule

// ===== hdl/hcsd_checker.sv =====
// hcsd_checker: port-level assertions for hchacha20_subkey_derive, bound to the top level
// depends only on the handshake and result ports of the top level
module hcsd_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_ready,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [63:0] rsp_subkey_bytes_0_7,
   input  logic [63:0] rsp_subkey_bytes_8_15,
   input  logic [63:0] rsp_subkey_bytes_16_23,
   input  logic [63:0] rsp_subkey_bytes_24_31
);

   // pipeline comes out of reset empty and open
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("pipeline not empty after reset");

   // input side only blocks when the whole pipeline backs up behind a stalled result
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input blocked without a stalled result");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped before transfer");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         $stable(rsp_subkey_bytes_0_7) && $stable(rsp_subkey_bytes_8_15) &&
         $stable(rsp_subkey_bytes_16_23) && $stable(rsp_subkey_bytes_24_31))
      else $error("stalled result changed");

endmodule

bind hchacha20_subkey_derive hcsd_checker u_hcsd_checker (.*);
